FILE: rtl/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, constants and tables of the trackball rotation update block.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int COORD_BITS_DEF       = 12;
    localparam int MATRIX_FRAC_BITS_DEF = 14;

    // width of Q.30 working values (angles, cordic, rotation entries)
    localparam int VW           = 36;
    // width of the serial multiplier accumulator
    localparam int AW           = 2 * VW + 2;
    localparam int STEP_W       = 7;
    localparam int CORDIC_STEPS = 28;
    // multiplier bits for Q.30 operands and for matrix entries
    localparam int RMUL_BITS    = 32;
    localparam int MMUL_BITS    = 16;
    localparam int RMUL_OPS     = 7;

    localparam logic [9:0] PPR_RESET = 10'd100;

    localparam logic signed [VW-1:0] Q30_ONE     = 36'sd1073741824;
    localparam logic signed [VW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [VW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [VW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    // above this, the reduced angle less two pi lies at or above minus half pi
    localparam logic signed [VW-1:0] FOLD_HI_Q30 = 36'sd5059889139;
    localparam logic signed [VW-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic [31:0]          AXIS_MAX    = 32'h4000_0000;

    localparam logic signed [AW-1:0] ROUND_Q30 = 74'sd536870912;
    localparam logic signed [AW-1:0] SAT_HI    = 74'sd32767;
    localparam logic signed [AW-1:0] SAT_LO    = -74'sd32768;

    localparam logic [1:0] MODE_PRESS   = 2'd0;
    localparam logic [1:0] MODE_MOVE    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_DIV_RX,
        ST_DIV_RY,
        ST_DIV_ANG,
        ST_DIV_MOD,
        ST_CORDIC,
        ST_RMUL,
        ST_MMUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic              clr;
        logic [STEP_W-1:0] nbits;
    } mul_cmd_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] nbits;
    } div_cmd_t;

    function automatic logic signed [VW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [VW-1:0] v;
        begin
            case (idx)
                5'd0:    v = 36'sd843314856;
                5'd1:    v = 36'sd497837829;
                5'd2:    v = 36'sd263043836;
                5'd3:    v = 36'sd133525158;
                5'd4:    v = 36'sd67021686;
                5'd5:    v = 36'sd33543515;
                5'd6:    v = 36'sd16775850;
                5'd7:    v = 36'sd8388437;
                5'd8:    v = 36'sd4194282;
                5'd9:    v = 36'sd2097149;
                5'd10:   v = 36'sd1048575;
                5'd11:   v = 36'sd524287;
                5'd12:   v = 36'sd262143;
                5'd13:   v = 36'sd131071;
                5'd14:   v = 36'sd65535;
                5'd15:   v = 36'sd32767;
                5'd16:   v = 36'sd16383;
                5'd17:   v = 36'sd8191;
                5'd18:   v = 36'sd4095;
                5'd19:   v = 36'sd2047;
                5'd20:   v = 36'sd1023;
                5'd21:   v = 36'sd511;
                5'd22:   v = 36'sd255;
                5'd23:   v = 36'sd127;
                5'd24:   v = 36'sd63;
                5'd25:   v = 36'sd31;
                5'd26:   v = 36'sd15;
                5'd27:   v = 36'sd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // row-major index of a 3x3 entry
    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        begin
            return {row, 2'b00} - {2'b00, row} + {2'b00, col};
        end
    endfunction

endpackage

FILE: rtl/trackball_rotation_update_unit.sv
// ----------------------------------------------------------------------------
// trackball_rotation_update_unit
// Turns a stored 3x3 Q1.14 orientation by pointer drags (Rodrigues rotation).
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one pointer event per transaction,
// mode (press, move, release) with pointer_x and pointer_y.
// Output channel (out_valid / out_stall): one transaction per event with the
// nine orientation entries m00..m22 after the event and the rotated flag.
// Config channel (cfg_valid / cfg_ready): pixels_per_radian, always ready;
// write it only while the block is idle.
// Events are handled one at a time. A press, an ignored event or a move
// without drag goes straight to the final state. A rotating event is
// dominated by the bit-serial multiplier: 7 rotation products and 27
// matrix products, plus square root, four serial divides and 28 cordic
// steps. Zero travel ends after the squared length. The result sits in
// an output register; the next event is accepted while it waits, and the
// block holds in its final state while an earlier result is still held
// by out_stall.
// Reset restores identity orientation, position zero, drag flag set and
// pixels_per_radian 100.
// ----------------------------------------------------------------------------
module trackball_rotation_update_unit
#(
    parameter int COORD_BITS       = trb_pkg::COORD_BITS_DEF,
    parameter int MATRIX_FRAC_BITS = trb_pkg::MATRIX_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [COORD_BITS-1:0]   pointer_x,
    input  logic [COORD_BITS-1:0]   pointer_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [15:0]      m00,
    output logic signed [15:0]      m01,
    output logic signed [15:0]      m02,
    output logic signed [15:0]      m10,
    output logic signed [15:0]      m11,
    output logic signed [15:0]      m12,
    output logic signed [15:0]      m20,
    output logic signed [15:0]      m21,
    output logic signed [15:0]      m22,
    output logic                    rotated,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [9:0]              cfg_data
);

    localparam int VW   = trb_pkg::VW;
    localparam int AW   = trb_pkg::AW;
    localparam int DW   = COORD_BITS + 1;
    localparam int SW   = 2 * COORD_BITS + 1;
    localparam int LW   = COORD_BITS + 15;
    localparam int RADW = 2 * LW;
    localparam int AQW  = LW + 17;
    localparam int QW   = AQW;
    localparam int DVW  = (LW > 33) ? LW : 33;
    localparam int AXW  = COORD_BITS + 45;
    localparam int STW  = $clog2(((LW > trb_pkg::CORDIC_STEPS) ? LW
                                  : trb_pkg::CORDIC_STEPS) + 1);
    localparam logic signed [15:0] M_ONE =
        (MATRIX_FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << MATRIX_FRAC_BITS);

    trb_pkg::state_t state_reg, state_next;

    logic [9:0]                 ppr_reg;
    logic [9:0]                 ppr_eff;
    logic [COORD_BITS-1:0]      last_x_reg;
    logic [COORD_BITS-1:0]      last_y_reg;
    logic                       drag_reg;
    logic signed [DW-1:0]       dx_reg;
    logic signed [DW-1:0]       dy_reg;
    logic                       issued_reg;
    logic [2:0]                 op_reg;
    logic [1:0]                 i_reg;
    logic [1:0]                 j_reg;
    logic [1:0]                 k_reg;
    logic [STW-1:0]             step_reg;
    logic                       rot_reg;
    logic                       upd_reg;

    logic [RADW-1:0]            rad_reg;
    logic [LW+1:0]              rrem_reg;
    logic [LW-1:0]              root_reg;
    logic [LW+3:0]              rrem2;
    logic [LW+3:0]              rtrial;

    logic [QW-1:0]              tq_reg;
    logic signed [VW-1:0]       rx_reg;
    logic signed [VW-1:0]       ry_reg;
    logic signed [VW-1:0]       cx_reg;
    logic signed [VW-1:0]       cy_reg;
    logic signed [VW-1:0]       cz_reg;
    logic                       flip_reg;
    logic signed [VW-1:0]       c_reg;
    logic signed [VW-1:0]       sn_reg;
    logic signed [VW-1:0]       omc_reg;
    logic signed [VW-1:0]       tq1_reg;
    logic signed [VW-1:0]       r_reg [9];
    logic signed [15:0]         m_reg [9];
    logic signed [15:0]         mnew_reg [9];
    logic signed [15:0]         mout_reg [9];
    logic                       out_valid_reg;
    logic                       rotated_out_reg;

    trb_pkg::mul_cmd_t          mul_cmd;
    logic signed [VW-1:0]       mul_a;
    logic signed [VW-1:0]       mul_b;
    logic signed [AW-1:0]       mul_acc;
    logic                       mul_busy;
    trb_pkg::div_cmd_t          div_cmd;
    logic [DVW-1:0]             div_rem_init;
    logic [QW-1:0]              div_dvd;
    logic [DVW-1:0]             div_divisor;
    logic [QW-1:0]              div_quo;
    logic [DVW-1:0]             div_rem;
    logic                       div_busy;

    logic                       in_acc;
    logic                       rot_event;
    logic                       mul_fin;
    logic                       div_fin;
    logic                       out_free;
    logic [SW-1:0]              sq_sum;
    logic [DW-1:0]              mag_full;
    logic [COORD_BITS-1:0]      mag;
    logic [AXW-1:0]             ax_dvd;
    logic [AQW-1:0]             ang_dvd;
    logic [31:0]                q_axis;
    logic [31:0]                q_clamp;
    logic signed [VW-1:0]       q_ext;
    logic signed [VW-1:0]       t_mod;
    logic signed [AW-1:0]       rnd_acc;
    logic signed [VW-1:0]       qv;
    logic signed [15:0]         sat_v;
    logic signed [VW-1:0]       xs;
    logic signed [VW-1:0]       ys;
    logic signed [VW-1:0]       c_fin;
    logic signed [VW-1:0]       s_fin;

    assign ppr_eff   = (ppr_reg == '0) ? 10'd1 : ppr_reg;
    assign in_acc    = in_valid && !in_stall;
    assign rot_event = (mode inside {trb_pkg::MODE_MOVE, trb_pkg::MODE_RELEASE}) && drag_reg;
    assign mul_fin   = issued_reg && !mul_busy;
    assign div_fin   = issued_reg && !div_busy;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sq_sum    = mul_acc[SW-1:0];

    // square root step, two radicand bits per cycle
    assign rrem2  = {rrem_reg, rad_reg[RADW-1 -: 2]};
    assign rtrial = {2'b00, root_reg, 2'b01};

    // axis component dividend: (|d| << 44) + len/2
    assign mag_full = ((state_reg == trb_pkg::ST_DIV_RX) ? dy_reg[DW-1] : dx_reg[DW-1])
                      ? DW'(-((state_reg == trb_pkg::ST_DIV_RX) ? dy_reg : dx_reg))
                      : ((state_reg == trb_pkg::ST_DIV_RX) ? dy_reg : dx_reg);
    assign mag      = mag_full[COORD_BITS-1:0];
    assign ax_dvd   = {1'b0, mag, 44'd0} + AXW'(root_reg >> 1);
    assign ang_dvd  = {1'b0, root_reg, 16'd0} + AQW'(ppr_eff[9:1]);

    assign q_axis  = div_quo[31:0];
    assign q_clamp = (q_axis > trb_pkg::AXIS_MAX) ? trb_pkg::AXIS_MAX : q_axis;
    assign q_ext   = {{(VW-32){1'b0}}, q_clamp};
    assign t_mod   = {{(VW-DVW){1'b0}}, div_rem};

    assign rnd_acc = (mul_acc + trb_pkg::ROUND_Q30) >>> 30;
    assign qv      = rnd_acc[VW-1:0];
    assign sat_v   = (rnd_acc > trb_pkg::SAT_HI) ? 16'sh7fff :
                     (rnd_acc < trb_pkg::SAT_LO) ? 16'sh8000 : rnd_acc[15:0];

    assign xs    = cx_reg >>> step_reg;
    assign ys    = cy_reg >>> step_reg;
    assign c_fin = flip_reg ? -cx_reg : cx_reg;
    assign s_fin = flip_reg ? -cy_reg : cy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trb_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = rot_event ? trb_pkg::ST_SQ : trb_pkg::ST_DONE;
                end
            end
            trb_pkg::ST_SQ:
            begin
                if (mul_fin && op_reg == 3'd1)
                begin
                    state_next = (sq_sum == '0) ? trb_pkg::ST_DONE : trb_pkg::ST_ROOT;
                end
            end
            trb_pkg::ST_ROOT:
            begin
                if (step_reg == STW'(LW - 1))
                begin
                    state_next = trb_pkg::ST_DIV_RX;
                end
            end
            trb_pkg::ST_DIV_RX:
            begin
                if (div_fin)
                begin
                    state_next = trb_pkg::ST_DIV_RY;
                end
            end
            trb_pkg::ST_DIV_RY:
            begin
                if (div_fin)
                begin
                    state_next = trb_pkg::ST_DIV_ANG;
                end
            end
            trb_pkg::ST_DIV_ANG:
            begin
                if (div_fin)
                begin
                    state_next = trb_pkg::ST_DIV_MOD;
                end
            end
            trb_pkg::ST_DIV_MOD:
            begin
                if (div_fin)
                begin
                    state_next = trb_pkg::ST_CORDIC;
                end
            end
            trb_pkg::ST_CORDIC:
            begin
                if (step_reg == STW'(trb_pkg::CORDIC_STEPS))
                begin
                    state_next = trb_pkg::ST_RMUL;
                end
            end
            trb_pkg::ST_RMUL:
            begin
                if (mul_fin && op_reg == 3'(trb_pkg::RMUL_OPS - 1))
                begin
                    state_next = trb_pkg::ST_MMUL;
                end
            end
            trb_pkg::ST_MMUL:
            begin
                if (mul_fin && i_reg == 2'd2 && j_reg == 2'd2 && k_reg == 2'd2)
                begin
                    state_next = trb_pkg::ST_DONE;
                end
            end
            trb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = trb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trb_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: unit commands and operands
    always_comb
    begin
        in_stall      = (state_reg != trb_pkg::ST_IDLE);
        mul_cmd       = '0;
        mul_a         = '0;
        mul_b         = '0;
        div_cmd       = '0;
        div_rem_init  = '0;
        div_dvd       = '0;
        div_divisor   = '0;
        case (state_reg)
            trb_pkg::ST_SQ:
            begin
                mul_cmd.start = !issued_reg;
                mul_cmd.clr   = (op_reg == 3'd0);
                mul_cmd.nbits = trb_pkg::STEP_W'(DW);
                if (op_reg == 3'd0)
                begin
                    mul_a = {{(VW-DW){dx_reg[DW-1]}}, dx_reg};
                end
                else
                begin
                    mul_a = {{(VW-DW){dy_reg[DW-1]}}, dy_reg};
                end
                mul_b = mul_a;
            end
            trb_pkg::ST_DIV_RX, trb_pkg::ST_DIV_RY:
            begin
                div_cmd.start = !issued_reg;
                div_cmd.nbits = trb_pkg::STEP_W'(32);
                div_rem_init  = DVW'(ax_dvd[AXW-1:32]);
                div_dvd       = {ax_dvd[31:0], {(QW-32){1'b0}}};
                div_divisor   = DVW'(root_reg);
            end
            trb_pkg::ST_DIV_ANG:
            begin
                div_cmd.start = !issued_reg;
                div_cmd.nbits = trb_pkg::STEP_W'(AQW);
                div_dvd       = ang_dvd;
                div_divisor   = DVW'(ppr_eff);
            end
            trb_pkg::ST_DIV_MOD:
            begin
                div_cmd.start = !issued_reg;
                div_cmd.nbits = trb_pkg::STEP_W'(AQW);
                div_dvd       = tq_reg;
                div_divisor   = trb_pkg::TWO_PI_Q30[DVW-1:0];
            end
            trb_pkg::ST_RMUL:
            begin
                mul_cmd.start = !issued_reg;
                mul_cmd.clr   = 1'b1;
                mul_cmd.nbits = trb_pkg::STEP_W'(trb_pkg::RMUL_BITS);
                case (op_reg)
                    3'd0:    begin mul_a = omc_reg; mul_b = rx_reg; end
                    3'd1:    begin mul_a = tq1_reg; mul_b = rx_reg; end
                    3'd2:    begin mul_a = tq1_reg; mul_b = ry_reg; end
                    3'd3:    begin mul_a = omc_reg; mul_b = ry_reg; end
                    3'd4:    begin mul_a = tq1_reg; mul_b = ry_reg; end
                    3'd5:    begin mul_a = ry_reg;  mul_b = sn_reg; end
                    default: begin mul_a = rx_reg;  mul_b = sn_reg; end
                endcase
            end
            trb_pkg::ST_MMUL:
            begin
                mul_cmd.start = !issued_reg;
                mul_cmd.clr   = (k_reg == 2'd0);
                mul_cmd.nbits = trb_pkg::STEP_W'(trb_pkg::MMUL_BITS);
                mul_a = r_reg[trb_pkg::idx3(k_reg, j_reg)];
                mul_b = {{(VW-16){m_reg[trb_pkg::idx3(i_reg, k_reg)][15]}},
                         m_reg[trb_pkg::idx3(i_reg, k_reg)]};
            end
            default:
            begin
                mul_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg         <= trb_pkg::PPR_RESET;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            drag_reg        <= 1'b1;
            issued_reg      <= 1'b0;
            op_reg          <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            step_reg        <= '0;
            rot_reg         <= 1'b0;
            upd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int n = 0; n < 9; n++)
            begin
                m_reg[n] <= ((n % 4) == 0) ? M_ONE : 16'sd0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                ppr_reg <= cfg_data;
            end

            if ((state_reg == trb_pkg::ST_SQ || state_reg == trb_pkg::ST_RMUL ||
                 state_reg == trb_pkg::ST_MMUL) && !issued_reg)
            begin
                issued_reg <= 1'b1;
            end
            else if ((state_reg == trb_pkg::ST_DIV_RX || state_reg == trb_pkg::ST_DIV_RY ||
                      state_reg == trb_pkg::ST_DIV_ANG || state_reg == trb_pkg::ST_DIV_MOD)
                     && !issued_reg)
            begin
                issued_reg <= 1'b1;
            end
            else if ((mul_fin && (state_reg == trb_pkg::ST_SQ ||
                                  state_reg == trb_pkg::ST_RMUL ||
                                  state_reg == trb_pkg::ST_MMUL)) ||
                     (div_fin && (state_reg == trb_pkg::ST_DIV_RX ||
                                  state_reg == trb_pkg::ST_DIV_RY ||
                                  state_reg == trb_pkg::ST_DIV_ANG ||
                                  state_reg == trb_pkg::ST_DIV_MOD)))
            begin
                issued_reg <= 1'b0;
            end

            case (state_reg)
                trb_pkg::ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        rot_reg <= 1'b0;
                        upd_reg <= 1'b0;
                        op_reg  <= '0;
                        if (mode == trb_pkg::MODE_PRESS)
                        begin
                            drag_reg   <= 1'b1;
                            last_x_reg <= pointer_x;
                            last_y_reg <= pointer_y;
                        end
                        else if (rot_event)
                        begin
                            rot_reg    <= 1'b1;
                            last_x_reg <= pointer_x;
                            last_y_reg <= pointer_y;
                            if (mode == trb_pkg::MODE_RELEASE)
                            begin
                                drag_reg <= 1'b0;
                            end
                        end
                    end
                end
                trb_pkg::ST_SQ:
                begin
                    if (mul_fin)
                    begin
                        op_reg   <= op_reg + 3'd1;
                        step_reg <= '0;
                    end
                end
                trb_pkg::ST_ROOT:
                begin
                    step_reg <= step_reg + 1'b1;
                end
                trb_pkg::ST_DIV_MOD:
                begin
                    if (div_fin)
                    begin
                        step_reg <= '0;
                    end
                end
                trb_pkg::ST_CORDIC:
                begin
                    if (step_reg == STW'(trb_pkg::CORDIC_STEPS))
                    begin
                        op_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                trb_pkg::ST_RMUL:
                begin
                    if (mul_fin)
                    begin
                        op_reg <= op_reg + 3'd1;
                        i_reg  <= '0;
                        j_reg  <= '0;
                        k_reg  <= '0;
                    end
                end
                trb_pkg::ST_MMUL:
                begin
                    if (mul_fin)
                    begin
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= '0;
                            if (j_reg == 2'd2)
                            begin
                                j_reg <= '0;
                                i_reg <= i_reg + 2'd1;
                            end
                            else
                            begin
                                j_reg <= j_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                        if (i_reg == 2'd2 && j_reg == 2'd2 && k_reg == 2'd2)
                        begin
                            upd_reg <= 1'b1;
                        end
                    end
                end
                trb_pkg::ST_DONE:
                begin
                    if (out_free && upd_reg)
                    begin
                        for (int n = 0; n < 9; n++)
                        begin
                            m_reg[n] <= mnew_reg[n];
                        end
                    end
                end
                default:
                begin
                    op_reg <= op_reg;
                end
            endcase

            if (state_reg == trb_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            trb_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    dx_reg <= DW'({1'b0, pointer_x}) - DW'({1'b0, last_x_reg});
                    dy_reg <= DW'({1'b0, pointer_y}) - DW'({1'b0, last_y_reg});
                end
            end
            trb_pkg::ST_SQ:
            begin
                if (mul_fin)
                begin
                    rad_reg  <= RADW'({sq_sum, 28'd0});
                    rrem_reg <= '0;
                    root_reg <= '0;
                end
            end
            trb_pkg::ST_ROOT:
            begin
                rad_reg <= {rad_reg[RADW-3:0], 2'b00};
                if (rrem2 >= rtrial)
                begin
                    rrem_reg <= (LW+2)'(rrem2 - rtrial);
                    root_reg <= {root_reg[LW-2:0], 1'b1};
                end
                else
                begin
                    rrem_reg <= rrem2[LW+1:0];
                    root_reg <= {root_reg[LW-2:0], 1'b0};
                end
            end
            trb_pkg::ST_DIV_RX:
            begin
                if (div_fin)
                begin
                    rx_reg <= dy_reg[DW-1] ? q_ext : -q_ext;
                end
            end
            trb_pkg::ST_DIV_RY:
            begin
                if (div_fin)
                begin
                    ry_reg <= dx_reg[DW-1] ? q_ext : -q_ext;
                end
            end
            trb_pkg::ST_DIV_ANG:
            begin
                if (div_fin)
                begin
                    tq_reg <= div_quo;
                end
            end
            trb_pkg::ST_DIV_MOD:
            begin
                if (div_fin)
                begin
                    // fold into [-pi/2, pi/2], remembering a half turn
                    cx_reg <= trb_pkg::CORDIC_GAIN;
                    cy_reg <= '0;
                    if (t_mod > trb_pkg::HALF_PI_Q30 && t_mod < trb_pkg::FOLD_HI_Q30)
                    begin
                        cz_reg   <= t_mod - trb_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end
                    else if (t_mod >= trb_pkg::FOLD_HI_Q30)
                    begin
                        cz_reg   <= t_mod - trb_pkg::TWO_PI_Q30;
                        flip_reg <= 1'b0;
                    end
                    else
                    begin
                        cz_reg   <= t_mod;
                        flip_reg <= 1'b0;
                    end
                end
            end
            trb_pkg::ST_CORDIC:
            begin
                if (step_reg == STW'(trb_pkg::CORDIC_STEPS))
                begin
                    c_reg    <= c_fin;
                    sn_reg   <= s_fin;
                    omc_reg  <= trb_pkg::Q30_ONE - c_fin;
                    r_reg[8] <= c_fin;
                end
                else if (!cz_reg[VW-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - trb_pkg::atan_q30(5'(step_reg));
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + trb_pkg::atan_q30(5'(step_reg));
                end
            end
            trb_pkg::ST_RMUL:
            begin
                if (mul_fin)
                begin
                    case (op_reg)
                        3'd0:    tq1_reg <= qv;
                        3'd1:    r_reg[0] <= c_reg + qv;
                        3'd2:
                        begin
                            r_reg[1] <= qv;
                            r_reg[3] <= qv;
                        end
                        3'd3:    tq1_reg <= qv;
                        3'd4:    r_reg[4] <= c_reg + qv;
                        3'd5:
                        begin
                            r_reg[2] <= qv;
                            r_reg[6] <= -qv;
                        end
                        default:
                        begin
                            r_reg[5] <= -qv;
                            r_reg[7] <= qv;
                        end
                    endcase
                end
            end
            trb_pkg::ST_MMUL:
            begin
                if (mul_fin && k_reg == 2'd2)
                begin
                    mnew_reg[trb_pkg::idx3(i_reg, j_reg)] <= sat_v;
                end
            end
            trb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    rotated_out_reg <= rot_reg;
                    for (int n = 0; n < 9; n++)
                    begin
                        mout_reg[n] <= upd_reg ? mnew_reg[n] : m_reg[n];
                    end
                end
            end
            default:
            begin
                rotated_out_reg <= rotated_out_reg;
            end
        endcase
    end

    trb_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .acc   (mul_acc),
        .busy  (mul_busy)
    );

    trb_div
    #(
        .DVW (DVW),
        .QW  (QW)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .dvd      (div_dvd),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .rem      (div_rem),
        .busy     (div_busy)
    );

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign rotated   = rotated_out_reg;
    assign m00 = mout_reg[0];
    assign m01 = mout_reg[1];
    assign m02 = mout_reg[2];
    assign m10 = mout_reg[3];
    assign m11 = mout_reg[4];
    assign m12 = mout_reg[5];
    assign m20 = mout_reg[6];
    assign m21 = mout_reg[7];
    assign m22 = mout_reg[8];

endmodule

FILE: rtl/trb_mul.sv
// ----------------------------------------------------------------------------
// trb_mul
// Bit-serial signed shift-add multiplier with an accumulating result.
// ----------------------------------------------------------------------------
module trb_mul
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  trb_pkg::mul_cmd_t              cmd,
    input  logic signed [trb_pkg::VW-1:0]  a,
    input  logic signed [trb_pkg::VW-1:0]  b,
    output logic signed [trb_pkg::AW-1:0]  acc,
    output logic                           busy
);

    logic signed [trb_pkg::AW-1:0]     acc_reg;
    logic signed [trb_pkg::AW-1:0]     a_sh_reg;
    logic signed [trb_pkg::VW-1:0]     b_sh_reg;
    logic [trb_pkg::STEP_W-1:0]        cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            cnt_reg <= cmd.nbits;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            if (cmd.clr)
            begin
                acc_reg <= '0;
            end
            a_sh_reg <= {{(trb_pkg::AW-trb_pkg::VW){a[trb_pkg::VW-1]}}, a};
            b_sh_reg <= b;
        end
        else if (cnt_reg != '0)
        begin
            // the top multiplier bit carries negative weight
            if (b_sh_reg[0])
            begin
                if (cnt_reg == trb_pkg::STEP_W'(1))
                begin
                    acc_reg <= acc_reg - a_sh_reg;
                end
                else
                begin
                    acc_reg <= acc_reg + a_sh_reg;
                end
            end
            a_sh_reg <= a_sh_reg <<< 1;
            b_sh_reg <= b_sh_reg >>> 1;
        end
    end

    assign acc  = acc_reg;
    assign busy = (cnt_reg != '0);

endmodule

FILE: rtl/trb_div.sv
// ----------------------------------------------------------------------------
// trb_div
// Restoring divider, one quotient bit per cycle, with a preloaded remainder.
// ----------------------------------------------------------------------------
module trb_div
#(
    parameter int DVW = 33,
    parameter int QW  = 44
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  trb_pkg::div_cmd_t       cmd,
    input  logic [DVW-1:0]          rem_init,
    input  logic [QW-1:0]           dvd,
    input  logic [DVW-1:0]          divisor,
    output logic [QW-1:0]           quo,
    output logic [DVW-1:0]          rem,
    output logic                    busy
);

    logic [DVW-1:0]             rem_reg;
    logic [QW-1:0]              dvd_reg;
    logic [QW-1:0]              quo_reg;
    logic [DVW-1:0]             dvs_reg;
    logic [trb_pkg::STEP_W-1:0] cnt_reg;
    logic [DVW:0]               trial;
    logic                       fits;

    assign trial = {rem_reg, dvd_reg[QW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            cnt_reg <= cmd.nbits;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dvd;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= DVW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[DVW-1:0];
            end
            dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign busy = (cnt_reg != '0);

endmodule

FILE: rtl/trb_checker.sv
// ----------------------------------------------------------------------------
// trb_checker
// Port-level checks of the trackball rotation update block, bound to its top.
// ----------------------------------------------------------------------------
module trb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] m00,
    input logic               rotated
);

    // a held result keeps m00 and the rotated flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(m00) && $stable(rotated))
        else $error("held result changed");

    // one event at a time: busy right after a transaction is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an event is in flight");

    // a new result only appears right after the block was busy with an event
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an event");

endmodule

bind trackball_rotation_update_unit trb_checker u_trb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .m00       (m00),
    .rotated   (rotated)
);

FILE: sim/trackball_rotation_update_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackball_rotation_update_unit_test
// Drives pointer press, move and release events into the trackball block and
// checks every orientation result against a bit-exact fixed-point predictor
// of the Rodrigues update, over several pixels_per_radian settings.
// ----------------------------------------------------------------------------

class orientation_scoreboard;

    typedef struct {
        logic signed [15:0] m [9];
        logic               rotated;
    } pose_t;

    longint         mat [9];
    longint         last_x;
    longint         last_y;
    bit             dragging;
    longint         ppr;
    pose_t          pending_poses [$];
    int             errors;
    longint         atan_tab [28];

    function new();
        atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686,
                     33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                     524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                     2047, 1023, 511, 255, 127, 63, 31, 15, 7};
        for (int i = 0; i < 9; i++)
        begin
            mat[i] = (i % 4 == 0) ? 16384 : 0;
        end
        last_x   = 0;
        last_y   = 0;
        dragging = 1;
        ppr      = 100;
        errors   = 0;
    endfunction

    function longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint axis_part(longint d, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? -d : d;
        q   = ((mag << 44) + (len >> 1)) / len;
        if (q > 64'd1073741824)
            q = 64'd1073741824;
        return (d < 0) ? longint'(q) : -longint'(q);
    endfunction

    function void rotate_to(longint nx, longint ny);
        longint            dx;
        longint            dy;
        longint            r [9];
        longint            acc;
        longint            res;
        longint            nm [9];
        longint unsigned   sq;
        longint unsigned   len;
        longint unsigned   p;
        longint            rx;
        longint            ry;
        longint            t;
        longint            x;
        longint            y;
        longint            xs;
        longint            ys;
        longint            c;
        longint            sn;
        longint            omc;
        bit                flip;
        dx = nx - last_x;
        dy = ny - last_y;
        sq = dx * dx + dy * dy;
        last_x = nx;
        last_y = ny;
        if (sq == 0)
        begin
            for (int i = 0; i < 9; i++)
                r[i] = (i % 4 == 0) ? (64'sd1 <<< 30) : 0;
        end
        else
        begin
            len  = int_root(sq << 28);
            p    = (ppr == 0) ? 1 : ppr;
            rx   = axis_part(dy, len);
            ry   = axis_part(dx, len);
            t    = longint'((((len << 16) + (p >> 1)) / p)
                            % longint'(trb_pkg::TWO_PI_Q30));
            flip = 0;
            if (t >= longint'(trb_pkg::PI_Q30))
                t -= longint'(trb_pkg::TWO_PI_Q30);
            if (t > longint'(trb_pkg::HALF_PI_Q30))
            begin
                t -= longint'(trb_pkg::PI_Q30);
                flip = 1;
            end
            else if (t < -longint'(trb_pkg::HALF_PI_Q30))
            begin
                t += longint'(trb_pkg::PI_Q30);
                flip = 1;
            end
            x = longint'(trb_pkg::CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < 28; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (t >= 0)
                begin
                    x -= ys;
                    y += xs;
                    t -= atan_tab[i];
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    t += atan_tab[i];
                end
            end
            c    = flip ? -x : x;
            sn   = flip ? -y : y;
            omc  = (64'sd1 <<< 30) - c;
            r[0] = c + q30_mul(q30_mul(omc, rx), rx);
            r[1] = q30_mul(q30_mul(omc, rx), ry);
            r[2] = q30_mul(ry, sn);
            r[3] = r[1];
            r[4] = c + q30_mul(q30_mul(omc, ry), ry);
            r[5] = -q30_mul(rx, sn);
            r[6] = -r[2];
            r[7] = -r[5];
            r[8] = c;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += mat[i*3+k] * r[k*3+j];
                res = (acc + (64'sd1 <<< 29)) >>> 30;
                if (res > 32767)
                    res = 32767;
                if (res < -32768)
                    res = -32768;
                nm[i*3+j] = res;
            end
        mat = nm;
    endfunction

    // predicts the result of one accepted pointer event
    function void note_event(logic [1:0] md, logic [11:0] px, logic [11:0] py);
        pose_t p;
        p.rotated = 0;
        if (md == trb_pkg::MODE_PRESS)
        begin
            dragging = 1;
            last_x   = px;
            last_y   = py;
        end
        else if ((md == trb_pkg::MODE_MOVE || md == trb_pkg::MODE_RELEASE) && dragging)
        begin
            rotate_to(px, py);
            p.rotated = 1;
            if (md == trb_pkg::MODE_RELEASE)
                dragging = 0;
        end
        for (int i = 0; i < 9; i++)
            p.m[i] = mat[i][15:0];
        pending_poses.push_back(p);
    endfunction

    function void check_pose(logic signed [15:0] got [9], logic got_rot);
        pose_t e;
        if (pending_poses.size() == 0)
        begin
            $display("%0t: unexpected result transaction", $time);
            errors++;
            return;
        end
        e = pending_poses.pop_front();
        for (int i = 0; i < 9; i++)
        begin
            if (got[i] !== e.m[i])
            begin
                $display("%0t: m%0d%0d expected %0d actual %0d",
                         $time, i / 3, i % 3, e.m[i], got[i]);
                errors++;
            end
        end
        if (got_rot !== e.rotated)
        begin
            $display("%0t: rotated expected %0b actual %0b", $time, e.rotated, got_rot);
            errors++;
        end
    endfunction

endclass

module trackball_rotation_update_unit_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint     CYCLE_LIMIT = 20000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [11:0]        pointer_x;
    logic [11:0]        pointer_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic               rotated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [9:0]         cfg_data;

    orientation_scoreboard pose_sb;
    longint                cycles;
    int                    event_count;
    bit                    hold_request;
    bit                    quiet;
    logic [11:0]           cur_x;
    logic [11:0]           cur_y;

    trackball_rotation_update_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .pointer_x (pointer_x),
        .pointer_y (pointer_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22),
        .rotated   (rotated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        if (quiet)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(10, 80);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
            end
            out_stall <= (gap_len() != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pose_sb.check_pose('{m00, m01, m02, m10, m11, m12, m20, m21, m22}, rotated);
    end

    task automatic send_event(logic [1:0] md, logic [11:0] px, logic [11:0] py);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= md;
        pointer_x <= px;
        pointer_y <= py;
        do
            @(posedge clk);
        while (in_stall);
        pose_sb.note_event(md, px, py);
        event_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pose_sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_ppr(logic [9:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pose_sb.ppr = v;
    endtask

    task automatic drag_sequence();
        int          n;
        logic [11:0] step_x;
        logic [11:0] step_y;
        cur_x = 12'($urandom);
        cur_y = 12'($urandom);
        send_event(trb_pkg::MODE_PRESS, cur_x, cur_y);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cur_x = 12'($urandom);
                cur_y = 12'($urandom);
            end
            else
            begin
                step_x = 12'($urandom_range(0, 120)) - 12'd60;
                step_y = 12'($urandom_range(0, 120)) - 12'd60;
                cur_x  = cur_x + step_x;
                cur_y  = cur_y + step_y;
            end
            send_event(trb_pkg::MODE_MOVE, cur_x, cur_y);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            cur_x = cur_x + 12'($urandom_range(0, 40)) - 12'd20;
            send_event(trb_pkg::MODE_RELEASE, cur_x, cur_y);
        end
    endtask

    task automatic random_phase(int count);
        int start_count;
        start_count = event_count;
        while (event_count - start_count < count)
        begin
            if ($urandom_range(0, 19) == 0)
                quiet = ~quiet;
            if ($urandom_range(0, 3) != 0)
            begin
                drag_sequence();
            end
            else
            begin
                send_event($urandom_range(0, 1) ? MODE_UNUSED : trb_pkg::MODE_MOVE,
                           12'($urandom), 12'($urandom));
            end
        end
        quiet = 0;
    endtask

    initial
    begin
        pose_sb      = new();
        cycles       = 0;
        event_count  = 0;
        hold_request = 0;
        quiet        = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = trb_pkg::MODE_PRESS;
        pointer_x    = '0;
        pointer_y    = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset drag flag lets a move rotate straight away; zero travel first
        send_event(trb_pkg::MODE_MOVE, 12'd0, 12'd0);
        send_event(trb_pkg::MODE_MOVE, 12'd4095, 12'd4095);
        send_event(MODE_UNUSED, 12'd4095, 12'd0);
        send_event(trb_pkg::MODE_RELEASE, 12'd0, 12'd4095);
        send_event(trb_pkg::MODE_MOVE, 12'd100, 12'd100);
        send_event(trb_pkg::MODE_RELEASE, 12'd200, 12'd200);
        send_event(trb_pkg::MODE_PRESS, 12'd2048, 12'd2048);
        send_event(trb_pkg::MODE_MOVE, 12'd2048, 12'd2048);
        send_event(trb_pkg::MODE_MOVE, 12'd2049, 12'd2048);
        send_event(trb_pkg::MODE_MOVE, 12'd2049, 12'd2047);
        send_event(trb_pkg::MODE_MOVE, 12'd0, 12'd2047);
        send_event(trb_pkg::MODE_RELEASE, 12'd0, 12'd2047);

        write_ppr(10'd1);
        send_event(trb_pkg::MODE_PRESS, 12'd0, 12'd0);
        send_event(trb_pkg::MODE_MOVE, 12'd4095, 12'd0);
        send_event(trb_pkg::MODE_MOVE, 12'd4095, 12'd4095);
        send_event(trb_pkg::MODE_MOVE, 12'd3, 12'd2);
        send_event(trb_pkg::MODE_RELEASE, 12'd5, 12'd5);

        // zero acts as one
        write_ppr(10'd0);
        send_event(trb_pkg::MODE_PRESS, 12'd10, 12'd10);
        send_event(trb_pkg::MODE_MOVE, 12'd13, 12'd6);
        write_ppr(10'd1023);
        send_event(trb_pkg::MODE_MOVE, 12'd4095, 12'd1);
        send_event(trb_pkg::MODE_RELEASE, 12'd1, 12'd4095);

        write_ppr(10'd100);
        fork
            random_phase(300);
            begin
                repeat (200) @(posedge clk);
                hold_request = 1;
            end
        join
        write_ppr(10'($urandom_range(2, 1022)));
        random_phase(300);
        write_ppr(10'd1023);
        random_phase(220);
        write_ppr(10'd1);
        random_phase(150);
        write_ppr(10'($urandom));
        random_phase(150);

        drain();
        repeat (100) @(posedge clk);
        if (pose_sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/trb_pkg.sv
rtl/trb_mul.sv
rtl/trb_div.sv
rtl/trackball_rotation_update_unit.sv
rtl/trb_checker.sv
sim/trackball_rotation_update_unit_test.sv
